[rtl/core/ina_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ina_pkg
// Shared constants, register codes and transfer types of the allreduce
// aggregator.
// ----------------------------------------------------------------------------
package ina_pkg;

    localparam int DEF_SLOTS            = 64;
    localparam int DEF_WINDOW_AHEAD     = 16;
    localparam int DEF_WORDS_PER_PACKET = 64;

    // command fields sized for the largest slot count and packet length
    localparam int SLOT_FW = 12;
    localparam int POS_FW  = 10;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE     = 4'd1;

    localparam logic [5:0] GROUP_SIZE_RST = 6'd2;
    localparam logic [7:0] OPCODE_RST     = 8'd1;

    typedef struct packed {
        logic [5:0] group_size;
        logic [7:0] opcode;
    } cfg_t;

    typedef struct packed {
        logic               fwd;
        logic               first;
        logic               in_range;
        logic               last;
        logic [4:0]         bit_idx;
        logic [15:0]        sender;
        logic [31:0]        seq;
        logic [31:0]        word;
        logic [SLOT_FW-1:0] slot;
        logic [SLOT_FW-1:0] ahead;
        logic [POS_FW-1:0]  pos;
    } cmd_t;

endpackage

[rtl/core/ina_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ina_front
// Accepts payload words, tracks packet framing, classifies each word and
// works out its slot and the slot ahead in a short pipeline.
// ----------------------------------------------------------------------------
module ina_front
    import ina_pkg::*;
#(
    parameter int SLOTS            = DEF_SLOTS,
    parameter int WINDOW_AHEAD     = DEF_WINDOW_AHEAD,
    parameter int WORDS_PER_PACKET = DEF_WORDS_PER_PACKET
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               hold,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_is_ack,
    input  logic [7:0]         s_opcode,
    input  logic [15:0]        s_sender,
    input  logic [31:0]        s_seq,
    input  logic signed [31:0] s_word,
    input  logic               s_last_word,
    input  logic               q_full,
    output logic               push,
    output cmd_t               push_cmd
);

    localparam int POSC_W = $clog2(WORDS_PER_PACKET + 1);
    localparam int POS_W  = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
    localparam logic [POSC_W-1:0] WPP_C   = POSC_W'(WORDS_PER_PACKET);
    localparam logic [31:0]       RECIP   = 32'(64'h1_0000_0000 / 64'(SLOTS));
    localparam logic [31:0]       SLOTS_C = 32'(SLOTS);
    localparam logic [31:0]       WIN_C   = 32'(WINDOW_AHEAD);

    logic [POSC_W-1:0] wp_reg, wp_next;

    logic        f1_valid_reg, f2_valid_reg, f3_valid_reg;
    cmd_t        f1_cmd_reg, f2_cmd_reg, f3_cmd_reg;
    logic [31:0] f1_seqw_reg, f2_seqw_reg, f3_seqw_reg;
    logic [31:0] f2_qs_reg, f2_qa_reg;
    logic [31:0] f3_ms_reg, f3_ma_reg;

    logic        adv, accept, fwd, drop;
    logic [5:0]  member_cnt;
    cmd_t        in_cmd;
    logic [63:0] prod_s, prod_a;
    logic [31:0] mul_s, mul_a;
    logic [31:0] rs_raw, ra_raw, rs, ra;

    assign adv     = !(f3_valid_reg && q_full);
    assign s_ready = adv && !hold;
    assign accept  = s_valid && s_ready;

    // classification
    always_comb begin
        fwd        = s_is_ack || (s_opcode != cfg.opcode);
        member_cnt = (cfg.group_size >= 6'd32) ? 6'd32 : cfg.group_size;
        drop       = !fwd && ({10'd0, member_cnt} <= s_sender);

        in_cmd          = '0;
        in_cmd.fwd      = fwd;
        in_cmd.first    = (wp_reg == '0);
        in_cmd.in_range = (wp_reg < WPP_C);
        in_cmd.last     = s_last_word;
        in_cmd.bit_idx  = s_sender[4:0];
        in_cmd.sender   = s_sender;
        in_cmd.seq      = s_seq;
        in_cmd.word     = $unsigned(s_word);
        in_cmd.pos      = POS_FW'(wp_reg[POS_W-1:0]);

        wp_next = wp_reg;
        if (accept) begin
            if (s_last_word) begin
                wp_next = '0;
            end else if (wp_reg < WPP_C) begin
                wp_next = wp_reg + POSC_W'(1);
            end
        end
    end

    // slot math: quotient estimate by reciprocal, then one correction
    assign prod_s = 64'(f1_cmd_reg.seq) * 64'(RECIP);
    assign prod_a = 64'(f1_seqw_reg) * 64'(RECIP);
    assign mul_s  = f2_qs_reg * SLOTS_C;
    assign mul_a  = f2_qa_reg * SLOTS_C;

    always_comb begin
        rs_raw = f3_cmd_reg.seq - f3_ms_reg;
        ra_raw = f3_seqw_reg - f3_ma_reg;
        rs     = (rs_raw >= SLOTS_C) ? (rs_raw - SLOTS_C) : rs_raw;
        ra     = (ra_raw >= SLOTS_C) ? (ra_raw - SLOTS_C) : ra_raw;

        push_cmd       = f3_cmd_reg;
        push_cmd.slot  = rs[SLOT_FW-1:0];
        push_cmd.ahead = ra[SLOT_FW-1:0];
    end

    assign push = f3_valid_reg && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else begin
            wp_reg <= wp_next;
            if (adv) begin
                f1_valid_reg <= accept && !drop;
                f2_valid_reg <= f1_valid_reg;
                f3_valid_reg <= f2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_cmd_reg  <= in_cmd;
            f1_seqw_reg <= s_seq + WIN_C;
            f2_cmd_reg  <= f1_cmd_reg;
            f2_seqw_reg <= f1_seqw_reg;
            f2_qs_reg   <= prod_s[63:32];
            f2_qa_reg   <= prod_a[63:32];
            f3_cmd_reg  <= f2_cmd_reg;
            f3_seqw_reg <= f2_seqw_reg;
            f3_ms_reg   <= mul_s;
            f3_ma_reg   <= mul_a;
        end
    end

endmodule

[rtl/core/ina_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ina_queue
// Small command queue between the classifying front and the slot engine.
// ----------------------------------------------------------------------------
module ina_queue
    import ina_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/ina_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ina_back
// Slot engine: member bitmap and sum stores, read-modify-write of each word,
// slot broadcast, zeroing of the slot ahead and the output register.
// ----------------------------------------------------------------------------
module ina_back
    import ina_pkg::*;
#(
    parameter int SLOTS            = DEF_SLOTS,
    parameter int WORDS_PER_PACKET = DEF_WORDS_PER_PACKET
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               head_valid,
    input  cmd_t               head_cmd,
    output logic               pop,
    output logic               init_busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [31:0]        m_out_seq,
    output logic [15:0]        m_out_sender,
    output logic signed [31:0] m_out_word,
    output logic               m_out_last
);

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int POS_W     = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
    localparam int ADDR_W    = SLOT_W + POS_W;
    localparam int SUM_DEPTH = SLOTS << POS_W;
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(WORDS_PER_PACKET - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    function automatic logic [31:0] member_mask(input logic [5:0] gs);
        logic [31:0] m;
        if (gs >= 6'd32) begin
            m = '1;
        end else begin
            m = (32'd1 << gs) - 32'd1;
        end
        return m;
    endfunction

    logic [31:0] sum_mem [SUM_DEPTH];
    logic [31:0] bm_mem  [SLOTS];

    logic        b1_valid_reg, b1_valid_next;
    cmd_t        b1_cmd_reg;
    logic [31:0] sum_rd_reg, bm_rd_reg;
    logic        byp_sum_hit_reg, byp_bm_hit_reg;
    logic [31:0] byp_sum_data_reg, byp_bm_data_reg;
    logic        acc_reg, full_reg;

    logic              clr_busy_reg, clr_busy_next;
    logic              clr_all_reg, clr_all_next;
    logic [SLOT_W-1:0] clr_slot_reg, clr_slot_next;
    logic [POS_W-1:0]  clr_pos_reg, clr_pos_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_kind_reg;
    logic [31:0] m_out_seq_reg;
    logic [15:0] m_out_sender_reg;
    logic [31:0] m_out_word_reg;
    logic        m_out_last_reg;

    logic [SLOT_W-1:0] head_slot, b1_slot;
    logic [ADDR_W-1:0] head_addr, b1_addr;
    logic [31:0]       bit_mask, bm_cur, sum_cur, sum_new, agg_word;
    logic              acc, full, emit, out_free, retire, wipe;
    logic              sum_we_b, bm_we_b;
    logic              sum_we, bm_we;
    logic [ADDR_W-1:0] sum_waddr;
    logic [SLOT_W-1:0] bm_waddr;
    logic [31:0]       sum_wdata, bm_wdata;

    assign head_slot = head_cmd.slot[SLOT_W-1:0];
    assign head_addr = {head_slot, head_cmd.pos[POS_W-1:0]};
    assign b1_slot   = b1_cmd_reg.slot[SLOT_W-1:0];
    assign b1_addr   = {b1_slot, b1_cmd_reg.pos[POS_W-1:0]};

    // word processing
    always_comb begin
        bit_mask = 32'd1 << b1_cmd_reg.bit_idx;
        bm_cur   = byp_bm_hit_reg ? byp_bm_data_reg : bm_rd_reg;
        sum_cur  = byp_sum_hit_reg ? byp_sum_data_reg : sum_rd_reg;
        acc      = b1_cmd_reg.first ? ((bm_cur & bit_mask) == '0) : acc_reg;
        full     = b1_cmd_reg.first
                 ? ((bm_cur | (acc ? bit_mask : 32'd0)) == member_mask(cfg.group_size))
                 : full_reg;
        sum_new  = sum_cur + b1_cmd_reg.word;
        if (b1_cmd_reg.ahead == b1_cmd_reg.slot) begin
            agg_word = '0;
        end else begin
            agg_word = acc ? sum_new : sum_cur;
        end

        emit     = b1_valid_reg && (b1_cmd_reg.fwd || (full && b1_cmd_reg.in_range));
        out_free = !m_valid_reg || m_ready;
        retire   = b1_valid_reg && (!emit || out_free);
        sum_we_b = retire && !b1_cmd_reg.fwd && acc && b1_cmd_reg.in_range;
        bm_we_b  = retire && !b1_cmd_reg.fwd && b1_cmd_reg.last && acc;
        wipe     = retire && !b1_cmd_reg.fwd && b1_cmd_reg.last && full;
        pop      = head_valid && !clr_busy_reg && (!b1_valid_reg || retire) && !wipe;

        b1_valid_next = b1_valid_reg;
        if (pop) begin
            b1_valid_next = 1'b1;
        end else if (retire) begin
            b1_valid_next = 1'b0;
        end
    end

    // store write ports shared between the word path and the zeroing sweep
    always_comb begin
        sum_we    = clr_busy_reg || sum_we_b;
        sum_waddr = clr_busy_reg ? {clr_slot_reg, clr_pos_reg} : b1_addr;
        sum_wdata = clr_busy_reg ? 32'd0 : sum_new;
        bm_we     = (clr_busy_reg && (clr_pos_reg == '0)) || bm_we_b;
        bm_waddr  = clr_busy_reg ? clr_slot_reg : b1_slot;
        bm_wdata  = clr_busy_reg ? 32'd0 : (bm_cur | bit_mask);
    end

    // zeroing sweep: whole store after reset, one slot after a broadcast
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_all_next  = clr_all_reg;
        clr_slot_next = clr_slot_reg;
        clr_pos_next  = clr_pos_reg;
        if (clr_busy_reg) begin
            if (clr_pos_reg == LAST_POS) begin
                clr_pos_next = '0;
                if (clr_all_reg && (clr_slot_reg != LAST_SLOT)) begin
                    clr_slot_next = clr_slot_reg + SLOT_W'(1);
                end else begin
                    clr_busy_next = 1'b0;
                    clr_all_next  = 1'b0;
                end
            end else begin
                clr_pos_next = clr_pos_reg + POS_W'(1);
            end
        end else if (wipe) begin
            clr_busy_next = 1'b1;
            clr_all_next  = 1'b0;
            clr_slot_next = b1_cmd_reg.ahead[SLOT_W-1:0];
            clr_pos_next  = '0;
        end
    end

    assign init_busy = clr_busy_reg && clr_all_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (retire && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (pop) begin
            sum_rd_reg <= sum_mem[head_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (pop) begin
            bm_rd_reg <= bm_mem[head_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            acc_reg      <= 1'b0;
            full_reg     <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_all_reg  <= 1'b1;
            clr_slot_reg <= '0;
            clr_pos_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            b1_valid_reg <= b1_valid_next;
            clr_busy_reg <= clr_busy_next;
            clr_all_reg  <= clr_all_next;
            clr_slot_reg <= clr_slot_next;
            clr_pos_reg  <= clr_pos_next;
            m_valid_reg  <= m_valid_next;
            if (retire && !b1_cmd_reg.fwd && b1_cmd_reg.first) begin
                acc_reg  <= acc;
                full_reg <= full;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b1_cmd_reg       <= head_cmd;
            byp_sum_hit_reg  <= sum_we_b && (b1_addr == head_addr);
            byp_sum_data_reg <= sum_new;
            byp_bm_hit_reg   <= bm_we_b && (b1_slot == head_slot);
            byp_bm_data_reg  <= bm_cur | bit_mask;
        end
        if (retire && emit) begin
            m_kind_reg       <= !b1_cmd_reg.fwd;
            m_out_seq_reg    <= b1_cmd_reg.seq;
            m_out_sender_reg <= b1_cmd_reg.fwd ? b1_cmd_reg.sender : 16'd0;
            m_out_word_reg   <= b1_cmd_reg.fwd ? b1_cmd_reg.word : agg_word;
            m_out_last_reg   <= b1_cmd_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_out_seq    = m_out_seq_reg;
    assign m_out_sender = m_out_sender_reg;
    assign m_out_word   = $signed(m_out_word_reg);
    assign m_out_last   = m_out_last_reg;

endmodule

[rtl/core/in_network_allreduce_aggregator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_network_allreduce_aggregator
// Throughput: one payload word per cycle while the queue has room and no
//   sweep runs; after the last word of a completed slot the slot engine
//   pauses while the slot ahead is zeroed through the single write port of
//   the sum store.
// Reset: zeroes the stores with s_ready low; configuration writes are taken
//   throughout.
// ----------------------------------------------------------------------------
module in_network_allreduce_aggregator
    import ina_pkg::*;
#(
    parameter int SLOTS            = DEF_SLOTS,
    parameter int WINDOW_AHEAD     = DEF_WINDOW_AHEAD,
    parameter int WORDS_PER_PACKET = DEF_WORDS_PER_PACKET
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_is_ack,
    input  logic [7:0]            s_opcode,
    input  logic [15:0]           s_sender,
    input  logic [31:0]           s_seq,
    input  logic signed [31:0]    s_word,
    input  logic                  s_last_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [31:0]           m_out_seq,
    output logic [15:0]           m_out_sender,
    output logic signed [31:0]    m_out_word,
    output logic                  m_out_last
);

    cfg_t cfg_reg;
    logic q_full, push, pop, head_valid, init_busy;
    cmd_t push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.group_size <= GROUP_SIZE_RST;
            cfg_reg.opcode     <= OPCODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GROUP_SIZE: cfg_reg.group_size <= cfg_data[5:0];
                CFG_OPCODE:     cfg_reg.opcode     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ina_front #(
        .SLOTS            (SLOTS),
        .WINDOW_AHEAD     (WINDOW_AHEAD),
        .WORDS_PER_PACKET (WORDS_PER_PACKET)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .hold        (init_busy),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_is_ack    (s_is_ack),
        .s_opcode    (s_opcode),
        .s_sender    (s_sender),
        .s_seq       (s_seq),
        .s_word      (s_word),
        .s_last_word (s_last_word),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    ina_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ina_back #(
        .SLOTS            (SLOTS),
        .WORDS_PER_PACKET (WORDS_PER_PACKET)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .init_busy    (init_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_seq    (m_out_seq),
        .m_out_sender (m_out_sender),
        .m_out_word   (m_out_word),
        .m_out_last   (m_out_last)
    );

endmodule

[rtl/core/ina_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ina_checker
// Port-level checks of the allreduce aggregator, bound to the top level.
// ----------------------------------------------------------------------------
module ina_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_kind,
    input logic [31:0]        m_out_seq,
    input logic [15:0]        m_out_sender,
    input logic signed [31:0] m_out_word,
    input logic               m_out_last
);

    // reset leaves no result pending and the input closed for the sweep
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or input open right after reset");

    a_sweep_closed: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !s_ready)
        else $error("input opened before store sweep finished");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_out_seq)
            && $stable(m_out_word) && $stable(m_out_last))
        else $error("stalled result changed");

    // aggregated words carry no connection id
    a_agg_sender: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_out_sender == 16'd0)
        else $error("aggregated word with nonzero sender");

endmodule

bind in_network_allreduce_aggregator ina_checker u_ina_checker (.*);

[tb/sv/ina_aggregate_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ina_aggregate_checker
// Watches the register, word and result channels of the allreduce
// aggregator. Keeps its own copy of the slot bitmaps, slot sums and packet
// framing, works out the result of every accepted word transfer and compares
// each result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ina_aggregate_checker
    import ina_pkg::*;
#(
    parameter int SLOTS            = DEF_SLOTS,
    parameter int WINDOW_AHEAD     = DEF_WINDOW_AHEAD,
    parameter int WORDS_PER_PACKET = DEF_WORDS_PER_PACKET
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_is_ack,
    input  logic [7:0]            s_opcode,
    input  logic [15:0]           s_sender,
    input  logic [31:0]           s_seq,
    input  logic [31:0]           s_word,
    input  logic                  s_last_word,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_kind,
    input  logic [31:0]           m_out_seq,
    input  logic [15:0]           m_out_sender,
    input  logic [31:0]           m_out_word,
    input  logic                  m_out_last,
    output int                    mismatch_count,
    output int                    pending_results,
    output int                    results_checked,
    output int                    sums_checked
);

    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [15:0] sender;
        logic [31:0] word;
        logic        last;
    } egress_t;

    egress_t     egress_q[$];
    logic [31:0] slot_members [SLOTS];
    logic [31:0] slot_totals [SLOTS*WORDS_PER_PACKET];
    int unsigned frame_pos;
    logic        pkt_accept;
    logic        pkt_full;
    logic [5:0]  grp_size;
    logic [7:0]  agg_opcode;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100) begin
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     what, results_checked, got, want);
        end
        mismatch_count++;
    endtask

    task automatic queue_egress(input logic kind, input logic [31:0] sq,
                                input logic [15:0] snd, input logic [31:0] wd,
                                input logic lst);
        egress_t e;
        e.kind   = kind;
        e.seq    = sq;
        e.sender = snd;
        e.word   = wd;
        e.last   = lst;
        egress_q.push_back(e);
    endtask

    task automatic aggregate_word(input logic ack, input logic [7:0] op,
                                  input logic [15:0] snd, input logic [31:0] sq,
                                  input logic [31:0] wd, input logic lst);
        int unsigned pos;
        int unsigned members;
        int unsigned slot;
        int unsigned ahead;
        int unsigned idx;
        int unsigned k;
        logic [31:0] all_members;
        logic [31:0] bm;
        logic [31:0] one_hot;
        logic [31:0] ahead_seq;
        pos = frame_pos;
        if (pos < WORDS_PER_PACKET) frame_pos = pos + 1;
        if (lst) frame_pos = 0;
        members = (grp_size > 32) ? 32 : grp_size;
        if (ack || op != agg_opcode) begin
            queue_egress(1'b0, sq, snd, wd, lst);
        end else if (snd < members) begin
            slot        = sq % SLOTS;
            ahead_seq   = sq + 32'(WINDOW_AHEAD);
            ahead       = ahead_seq % SLOTS;
            one_hot     = 32'd1 << snd[4:0];
            all_members = (members >= 32) ? 32'hffff_ffff : ((32'd1 << members) - 32'd1);
            // accept and full are decided on the first word only
            if (pos == 0) begin
                bm = slot_members[slot];
                pkt_accept = (bm & one_hot) == 32'd0;
                if (pkt_accept) bm = bm | one_hot;
                pkt_full = (bm == all_members);
            end
            if (pos < WORDS_PER_PACKET) begin
                idx = slot * WORDS_PER_PACKET + pos;
                if (pkt_accept) slot_totals[idx] = slot_totals[idx] + wd;
                if (pkt_full) begin
                    queue_egress(1'b1, sq, 16'd0, (ahead == slot) ? 32'd0 : slot_totals[idx],
                                 lst);
                end
            end
            if (lst) begin
                if (pkt_accept) slot_members[slot] = slot_members[slot] | one_hot;
                if (pkt_full) begin
                    slot_members[ahead] = 32'd0;
                    for (k = 0; k < WORDS_PER_PACKET; k++) begin
                        slot_totals[ahead*WORDS_PER_PACKET + k] = 32'd0;
                    end
                end
            end
        end
    endtask

    task automatic check_egress();
        egress_t e;
        if (egress_q.size() == 0) begin
            report_mismatch("result with nothing expected", m_out_word, 32'd0);
        end else begin
            e = egress_q.pop_front();
            if (m_kind !== e.kind) report_mismatch("kind", 32'(m_kind), 32'(e.kind));
            if (m_out_seq !== e.seq) report_mismatch("out_seq", m_out_seq, e.seq);
            if (m_out_sender !== e.sender) begin
                report_mismatch("out_sender", 32'(m_out_sender), 32'(e.sender));
            end
            if (m_out_word !== e.word) report_mismatch("out_word", m_out_word, e.word);
            if (m_out_last !== e.last) report_mismatch("out_last", 32'(m_out_last), 32'(e.last));
            results_checked++;
            if (e.kind) sums_checked++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        int k;
        if (!aresetn) begin
            grp_size   = GROUP_SIZE_RST;
            agg_opcode = OPCODE_RST;
            for (k = 0; k < SLOTS; k++) slot_members[k] = 32'd0;
            for (k = 0; k < SLOTS*WORDS_PER_PACKET; k++) slot_totals[k] = 32'd0;
            frame_pos       = 0;
            pkt_accept      = 1'b0;
            pkt_full        = 1'b0;
            egress_q.delete();
            mismatch_count  = 0;
            results_checked = 0;
            sums_checked    = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_GROUP_SIZE) begin
                    grp_size = cfg_data[5:0];
                end else if (cfg_index == CFG_OPCODE) begin
                    agg_opcode = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                aggregate_word(s_is_ack, s_opcode, s_sender, s_seq, s_word, s_last_word);
            end
            if (m_valid && m_ready) check_egress();
        end
        pending_results = egress_q.size();
    end

endmodule

[tb/sv/tb_in_network_allreduce_aggregator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_in_network_allreduce_aggregator
// Drives the allreduce aggregator with a short directed sequence and then
// with random aggregation rounds, acks, foreign opcodes, dropped senders,
// overlong packets and header changes, under several register settings and
// idle patterns on both channels. The checker beside the block predicts and
// compares every result transfer.
// ----------------------------------------------------------------------------
module tb_in_network_allreduce_aggregator;
    import ina_pkg::*;

    localparam int WPP          = DEF_WORDS_PER_PACKET;
    localparam int DRAIN_CYCLES = 2 * WPP + 16;
    localparam int LONG_STALL   = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 290;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_is_ack;
    logic [7:0]            s_opcode;
    logic [15:0]           s_sender;
    logic [31:0]           s_seq;
    logic signed [31:0]    s_word;
    logic                  s_last_word;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_kind;
    logic [31:0]           m_out_seq;
    logic [15:0]           m_out_sender;
    logic signed [31:0]    m_out_word;
    logic                  m_out_last;

    int          mismatch_count;
    int          pending_results;
    int          results_checked;
    int          sums_checked;
    int          tx_idle_pct   = 0;
    int          rx_idle_pct   = 0;
    int          stall_req     = 0;
    int          stall_seen    = 0;
    int          stall_left    = 0;
    int          items_sent    = 0;
    int          settings_used = 0;
    int unsigned cycle_count   = 0;
    logic [5:0]  cur_gs        = GROUP_SIZE_RST;
    logic [7:0]  cur_op        = OPCODE_RST;
    logic [31:0] round_seq;

    always #1 aclk = ~aclk;

    in_network_allreduce_aggregator uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_is_ack     (s_is_ack),
        .s_opcode     (s_opcode),
        .s_sender     (s_sender),
        .s_seq        (s_seq),
        .s_word       (s_word),
        .s_last_word  (s_last_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_seq    (m_out_seq),
        .m_out_sender (m_out_sender),
        .m_out_word   (m_out_word),
        .m_out_last   (m_out_last)
    );

    ina_aggregate_checker agg_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_is_ack        (s_is_ack),
        .s_opcode        (s_opcode),
        .s_sender        (s_sender),
        .s_seq           (s_seq),
        .s_word          (s_word),
        .s_last_word     (s_last_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_out_seq       (m_out_seq),
        .m_out_sender    (m_out_sender),
        .m_out_word      (m_out_word),
        .m_out_last      (m_out_last),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .sums_checked    (sums_checked)
    );

    // result side: random back-pressure plus an occasional long hold-off
    always @(negedge aclk) begin
        if (stall_seen != stall_req) begin
            stall_seen = stall_req;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: begin
                return 32'h7fff_ffff;
            end
            1: begin
                return 32'h8000_0000;
            end
            2: begin
                return 32'h0000_0000;
            end
            3: begin
                return 32'hffff_ffff;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic send_word(input logic ack, input logic [7:0] op, input logic [15:0] snd,
                             input logic [31:0] sq, input logic [31:0] wd, input logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_is_ack    <= ack;
        s_opcode    <= op;
        s_sender    <= snd;
        s_seq       <= sq;
        s_word      <= wd;
        s_last_word <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_packet(input logic ack, input logic [7:0] op, input logic [15:0] snd,
                               input logic [31:0] sq, input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_word(ack, op, snd, sq, rand_word(), i == len - 1);
        end
    endtask

    task automatic send_noise();
        send_word(1'($urandom_range(1)),
                  ($urandom_range(3) == 0) ? cur_op : 8'($urandom_range(255)),
                  ($urandom_range(1) == 1) ? 16'($urandom_range(65535)) : 16'($urandom_range(31)),
                  $urandom, rand_word(), $urandom_range(3) != 0);
    endtask

    task automatic wait_drained(input int extra);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [5:0] gs, input logic [7:0] op);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_GROUP_SIZE;
        cfg_data  <= {2'b00, gs};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_index <= CFG_OPCODE;
        cfg_data  <= op;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_gs = gs;
        cur_op = op;
        settings_used++;
    endtask

    // each member, in random order, opens a packet on one sequence number
    task automatic run_round(input logic [31:0] sq);
        int members;
        int len;
        int plen;
        int pick;
        int tmp;
        int i;
        int order [32];
        members = (cur_gs > 32) ? 32 : cur_gs;
        for (i = 0; i < members; i++) order[i] = i;
        for (i = members - 1; i > 0; i--) begin
            pick = $urandom_range(i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        len = 1 + $urandom_range(3);
        if (members <= 4 && $urandom_range(24) == 0) len = WPP;
        for (i = 0; i < members; i++) begin
            if ($urandom_range(15) == 0) send_noise();
            plen = len;
            if ($urandom_range(9) == 0) plen = 1 + $urandom_range(5);
            if (members <= 4 && $urandom_range(39) == 0) plen = WPP + 1 + $urandom_range(2);
            if (plen > 1 && $urandom_range(19) == 0) begin
                // header changes after the first word of the packet
                send_word(1'b0, cur_op, 16'(order[i]), sq, rand_word(), 1'b0);
                send_packet(1'b0, cur_op, 16'($urandom_range(members - 1)), sq + 32'd1,
                            plen - 1);
            end else begin
                send_packet(1'b0, cur_op, 16'(order[i]), sq, plen);
            end
        end
        if ($urandom_range(3) == 0) begin
            send_packet(1'b0, cur_op, 16'(order[$urandom_range(members - 1)]), sq, len);
        end
        if ($urandom_range(7) == 0) begin
            send_packet(1'b0, cur_op, 16'(members + $urandom_range(65535 - members)), sq, len);
        end
    endtask

    task automatic run_phase(input logic [5:0] gs, input logic [7:0] op, input int tx_pct,
                             input int rx_pct, input logic long_hold);
        int target;
        wait_drained(DRAIN_CYCLES);
        program_regs(gs, op);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (long_hold) stall_req <= stall_req + 1;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(9) < 8) begin
                run_round(round_seq);
                round_seq = round_seq + 32'd1;
            end else begin
                repeat (1 + $urandom_range(3)) send_noise();
            end
            if ($urandom_range(29) == 0) wait_drained(0);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_GROUP_SIZE;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_is_ack    = 1'b0;
        s_opcode    = '0;
        s_sender    = '0;
        s_seq       = '0;
        s_word      = '0;
        s_last_word = 1'b0;
        m_ready     = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, first under the reset register values
        send_word(1'b1, 8'hff, 16'hffff, 32'hffff_ffff, 32'h8000_0000, 1'b1);
        send_word(1'b0, 8'h00, 16'h0000, 32'h0000_0000, 32'h7fff_ffff, 1'b1);
        send_word(1'b0, OPCODE_RST, 16'd0, 32'd5, 32'h7fff_ffff, 1'b0);
        send_word(1'b0, OPCODE_RST, 16'd0, 32'd5, 32'hffff_ffff, 1'b1);
        send_word(1'b0, OPCODE_RST, 16'd1, 32'd5, 32'h0000_0001, 1'b0);
        send_word(1'b0, OPCODE_RST, 16'd1, 32'd5, 32'h8000_0000, 1'b1);
        // repeat contribution to a slot that is already complete
        send_word(1'b0, OPCODE_RST, 16'd1, 32'd5, 32'h1234_5678, 1'b0);
        send_word(1'b0, OPCODE_RST, 16'd1, 32'd5, 32'h0000_0000, 1'b1);
        send_word(1'b0, OPCODE_RST, 16'd2, 32'd6, 32'h0000_0003, 1'b1);
        send_word(1'b0, OPCODE_RST, 16'hffff, 32'd6, 32'h0000_0004, 1'b1);
        send_word(1'b0, OPCODE_RST, 16'd0, 32'd7, 32'h0000_0011, 1'b0);
        send_word(1'b0, OPCODE_RST, 16'd1, 32'd8, 32'h0000_0022, 1'b1);
        send_word(1'b0, OPCODE_RST, 16'd1, 32'd8, 32'h0000_0033, 1'b0);
        send_word(1'b0, OPCODE_RST, 16'd1, 32'd8, 32'h0000_0044, 1'b1);
        // an ack word opens the frame, the aggregate word lands at position one
        send_word(1'b1, OPCODE_RST, 16'd0, 32'd9, 32'h0000_0055, 1'b0);
        send_word(1'b0, OPCODE_RST, 16'd0, 32'd9, 32'h0000_0066, 1'b1);
        wait_drained(DRAIN_CYCLES);
        program_regs(6'd0, 8'h80);
        send_word(1'b0, 8'h80, 16'd0, 32'd10, 32'h0000_0077, 1'b1);
        send_word(1'b0, OPCODE_RST, 16'd0, 32'd10, 32'h0000_0088, 1'b1);
        wait_drained(DRAIN_CYCLES);
        program_regs(6'd32, 8'hff);
        send_word(1'b0, 8'hff, 16'd31, 32'd11, 32'h8000_0000, 1'b1);
        send_word(1'b0, 8'hff, 16'd32, 32'd11, 32'h7fff_ffff, 1'b1);

        round_seq = $urandom;
        run_phase(6'd1, 8'h00, 25, 71, 1'b0);
        run_phase(6'd32, 8'hff, 25, 71, 1'b0);
        run_phase(6'd5, 8'($urandom), 71, 25, 1'b0);
        run_phase(6'd63, 8'($urandom), 71, 25, 1'b0);
        run_phase(6'd2, OPCODE_RST, 0, 0, 1'b1);
        round_seq = 32'hffff_ffe0;
        run_phase(6'($urandom_range(3, 31)), 8'($urandom), 0, 0, 1'b1);

        wait_drained(DRAIN_CYCLES);
        $display("sent %0d word transfers under %0d register settings", items_sent,
                 settings_used);
        $display("checked %0d result transfers, %0d of them slot sums", results_checked,
                 sums_checked);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
